// File: rtl/upd_pkg.sv
// upd_pkg: shared types and character constants for the url percent decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package upd_pkg;

  // one input beat
  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_string;
  } upd_in_t;

  // one result beat
  typedef struct packed {
    logic [7:0] out_char;
    logic       is_terminator;
    logic       last_of_run;
  } upd_out_t;

  // most results one input byte can cause
  localparam int RunMax = 3;

  // results caused by one input beat; a terminator is always the last one
  typedef struct packed {
    logic [1:0]              cnt;
    logic [RunMax-1:0][7:0]  chars;
    logic                    term;
  } upd_run_t;

  // run queue between front and back
  localparam int QueueAw    = 2;
  localparam int QueueDepth = 1 << QueueAw;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharNul     = 8'h00;

endpackage

`default_nettype wire

// File: rtl/upd_front.sv
// upd_front: escape tracking and classification of each input byte into a run.
// Depends on upd_pkg; feeds upd_queue.
`default_nettype none

module upd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire upd_pkg::upd_in_t in_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             q_ready_i,
  output upd_pkg::upd_run_t     run_o,
  output logic                  push_o
);
  import upd_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhPercent,
    PhDigit
  } phase_e;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v[3:0];
  endfunction

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;

  upd_run_t               run;
  logic [1:0]             pfx_cnt;
  logic [RunMax-1:0][7:0] pfx_chars;
  logic                   accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    // literal flush of a pending escape
    pfx_chars = '0;
    case (phase_q)
      PhPercent: begin
        pfx_cnt      = 2'd1;
        pfx_chars[0] = CharPercent;
      end
      PhDigit: begin
        pfx_cnt      = 2'd2;
        pfx_chars[0] = CharPercent;
        pfx_chars[1] = held_q;
      end
      default: begin
        pfx_cnt = 2'd0;
      end
    endcase

    run     = '0;
    phase_d = PhIdle;
    held_d  = CharNul;

    if (in_i.end_of_string) begin
      run.chars = pfx_chars;
      run.cnt   = 2'(pfx_cnt + 2'd1);
      run.term  = 1'b1;
    end else if (phase_q == PhPercent && is_hex(in_i.in_char)) begin
      phase_d = PhDigit;
      held_d  = in_i.in_char;
    end else if (phase_q == PhDigit && is_hex(in_i.in_char)) begin
      run.chars[0] = {hex_value(held_q), hex_value(in_i.in_char)};
      run.cnt      = 2'd1;
    end else begin
      run.chars = pfx_chars;
      if (in_i.in_char == CharPercent) begin
        run.cnt = pfx_cnt;
        phase_d = PhPercent;
      end else begin
        run.chars[pfx_cnt] = (in_i.in_char == CharPlus) ? CharSpace : in_i.in_char;
        run.cnt            = 2'(pfx_cnt + 2'd1);
      end
    end
  end

  assign run_o  = run;
  assign push_o = accept && (run.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= CharNul;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/upd_queue.sv
// upd_queue: small flop-based queue of runs between front and back.
// Depends on upd_pkg for the run type and depth.
`default_nettype none

module upd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire upd_pkg::upd_run_t run_i,
  output logic                   ready_o,
  input  wire logic              pop_i,
  output upd_pkg::upd_run_t      head_o,
  output logic                   head_valid_o
);
  import upd_pkg::*;

  localparam logic [QueueAw:0] FullCnt = (QueueAw + 1)'(QueueDepth);

  upd_run_t           mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   cnt_q, cnt_d;

  assign ready_o      = cnt_q != FullCnt;
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= run_i;
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ready_o) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count out of range");

endmodule

`default_nettype wire

// File: rtl/upd_back.sv
// upd_back: unrolls queued runs into single results through an output register.
// Depends on upd_pkg; pops from upd_queue.
`default_nettype none

module upd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire upd_pkg::upd_run_t head_i,
  input  wire logic              head_valid_i,
  output logic                   pop_o,
  output upd_pkg::upd_out_t      out_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i
);
  import upd_pkg::*;

  logic [1:0] idx_q;
  logic       out_valid_q;
  upd_out_t   out_q;
  logic       load;
  logic       last_el;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign last_el = idx_q == 2'(head_i.cnt - 2'd1);
  assign pop_o   = load && last_el;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= last_el ? 2'd0 : 2'(idx_q + 2'd1);
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // terminator slot carries a zero byte from the front
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_char      <= head_i.chars[idx_q];
      out_q.is_terminator <= head_i.term && last_el;
      out_q.last_of_run   <= last_el;
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_terminator |-> out_q.last_of_run)
    else $error("terminator not last of run");
  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_terminator |-> out_q.out_char == CharNul)
    else $error("terminator carries nonzero byte");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> head_i.cnt != 2'd0 && idx_q < head_i.cnt)
    else $error("run index beyond run length");

endmodule

`default_nettype wire

// File: rtl/url_percent_decoder_core.sv
// url_percent_decoder_core: form-style url percent decoder, top level.
// Instantiates upd_front, upd_queue and upd_back; types from upd_pkg.
`default_nettype none

// Takes one encoded byte per beat and returns decoded bytes: %hh (either case) gives the
// byte, plus gives a space, a broken escape is passed on literally, and an end-of-string
// beat flushes any pending escape and then gives a terminator result. The input side
// accepts one beat per cycle while the four-entry run queue has room; the output side
// delivers one result per cycle from its output register while the receiver is ready. A
// byte that causes two or three results (a broken escape, or end of string after a
// pending escape) holds the output for all of them; the queue absorbs such bursts, so
// sustained input rate is one byte per cycle as long as results average no more than one
// per byte and the output is not stalled. Runs pass through the queue into the output register.
module url_percent_decoder_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire upd_pkg::upd_in_t in_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output upd_pkg::upd_out_t     out_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i
);
  import upd_pkg::*;

  upd_run_t run;
  upd_run_t head;
  logic     push;
  logic     q_ready;
  logic     pop;
  logic     head_valid;

  upd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .q_ready_i (q_ready),
    .run_o     (run),
    .push_o    (push)
  );

  upd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .run_i       (run),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .head_o      (head),
    .head_valid_o(head_valid)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule

`default_nettype wire

// File: test/url_percent_decoder_core_test.sv
// Self-checking testbench for url_percent_decoder_core: directed and random encoded strings,
// a scoreboard class that predicts every decoded beat, and random input bursts and output stalls.
// Depends on upd_pkg for the beat structs and the character constants.
module url_percent_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  localparam int          StallLimit = 1500;
  localparam int          RandItems  = 280;
  localparam int          LongHold   = 150;
  localparam logic [7:0]  CharZero   = "0";
  localparam logic [7:0]  CharNine   = "9";
  localparam logic [7:0]  CharLowA   = "a";
  localparam logic [7:0]  CharLowF   = "f";
  localparam logic [7:0]  CharUpA    = "A";
  localparam logic [7:0]  CharUpF    = "F";

  typedef enum logic [1:0] {
    EscIdle,
    EscPercent,
    EscDigit
  } esc_phase_e;

  class url_decode_scoreboard;
    upd_out_t    decoded_q[$];
    upd_out_t    run_q[$];
    esc_phase_e  esc;
    logic [7:0]  held;
    int unsigned errors;

    function new();
      esc    = EscIdle;
      held   = '0;
      errors = 0;
    endfunction

    function bit is_hex_char(logic [7:0] c);
      return (c >= CharZero && c <= CharNine) || (c >= CharLowA && c <= CharLowF) ||
             (c >= CharUpA && c <= CharUpF);
    endfunction

    function logic [3:0] hex_nibble(logic [7:0] c);
      logic [7:0] v;
      if (c >= CharZero && c <= CharNine) v = c - CharZero;
      else if (c >= CharLowA && c <= CharLowF) v = c - CharLowA + 8'd10;
      else v = c - CharUpA + 8'd10;
      return v[3:0];
    endfunction

    function void emit_byte(logic [7:0] c, logic term);
      upd_out_t r;
      r.out_char      = c;
      r.is_terminator = term;
      r.last_of_run   = 1'b0;
      run_q.push_back(r);
    endfunction

    // a pending escape goes out literally: percent, then the held digit if any
    function void flush_escape();
      if (esc != EscIdle) emit_byte(CharPercent, 1'b0);
      if (esc == EscDigit) emit_byte(held, 1'b0);
      esc  = EscIdle;
      held = '0;
    endfunction

    function void note_encoded_beat(upd_in_t b);
      logic [7:0] c;
      c = b.in_char;
      run_q.delete();
      if (b.end_of_string) begin
        flush_escape();
        emit_byte(CharNul, 1'b1);
      end else if (esc == EscPercent && is_hex_char(c)) begin
        held = c;
        esc  = EscDigit;
      end else if (esc == EscDigit && is_hex_char(c)) begin
        emit_byte({hex_nibble(held), hex_nibble(c)}, 1'b0);
        esc  = EscIdle;
        held = '0;
      end else begin
        flush_escape();
        if (c == CharPercent) esc = EscPercent;
        else if (c == CharPlus) emit_byte(CharSpace, 1'b0);
        else emit_byte(c, 1'b0);
      end
      if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
      foreach (run_q[i]) decoded_q.push_back(run_q[i]);
    endfunction

    function void check_decoded_beat(upd_out_t got);
      upd_out_t want;
      if (decoded_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected beat char=%02h term=%0b last=%0b", $realtime,
                   got.out_char, got.is_terminator, got.last_of_run);
        return;
      end
      want = decoded_q.pop_front();
      if (got.out_char !== want.out_char || got.is_terminator !== want.is_terminator ||
          got.last_of_run !== want.last_of_run) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp char=%02h term=%0b last=%0b got char=%02h term=%0b last=%0b",
                   $realtime, want.out_char, want.is_terminator, want.last_of_run,
                   got.out_char, got.is_terminator, got.last_of_run);
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  upd_in_t  in_i        = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  upd_out_t out_o;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;

  url_decode_scoreboard sb = new();
  int beats_in   = 0;
  int burst_left = 0;

  url_percent_decoder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // offer one beat, hold it until taken, then maybe idle before the next burst
  task automatic send_beat(upd_in_t b);
    in_i       <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_encoded_beat(b);
    beats_in++;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_char(logic [7:0] c);
    send_beat('{in_char: c, end_of_string: 1'b0});
  endtask

  // in_char is a don't-care on the end beat, so it is randomized
  task automatic send_end();
    send_beat('{in_char: 8'($urandom_range(0, 255)), end_of_string: 1'b1});
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] pick_hex();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return CharZero + 8'(v);
    if (v < 16) return CharLowA + 8'(v - 10);
    return CharUpA + 8'(v - 16);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (sb.is_hex_char(c));
    return c;
  endfunction

  initial begin : stimulus
    int kind;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("A");
    send_char(8'hFF);
    send_char(CharNul);
    send_text("+");
    send_text("%4a");
    send_text("%00");
    send_text("%Ff");
    send_text("%%41");
    send_text("%4G");
    send_text("%");
    send_end();
    send_text("%7");
    send_end();
    send_end();

    while (beats_in < RandItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_char(CharPercent);
        send_char(pick_hex());
        send_char(pick_hex());
      end else if (kind < 52) begin
        send_char(CharPlus);
      end else if (kind < 72) begin
        send_char(8'($urandom_range(1, 255)));
      end else if (kind < 84) begin
        // broken escape, cut after the percent or after one digit
        send_char(CharPercent);
        if ($urandom_range(0, 1)) send_char(pick_hex());
        send_char(pick_non_hex());
      end else if (kind < 92) begin
        if ($urandom_range(0, 1)) send_char(CharPercent);
        if ($urandom_range(0, 1)) send_char(pick_hex());
        send_end();
      end else begin
        send_char(8'($urandom_range(0, 255)));
      end
    end

    in_valid_i <= 1'b0;
    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // output side: stall patterns change per segment, plus one long hold-off
  initial begin : receiver
    int mode;
    int seg_left;
    int tick;
    bit held_off;
    mode     = 0;
    seg_left = 0;
    tick     = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (!held_off && beats_in >= 60) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(8, 60);
      end else begin
        seg_left--;
      end
      case (mode)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready_i <= (tick % 4) != 0;
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_decoded_beat(out_o);
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no beat moved for %0d cycles", StallLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
rtl/upd_pkg.sv
rtl/upd_front.sv
rtl/upd_queue.sv
rtl/upd_back.sv
rtl/url_percent_decoder_core.sv
test/url_percent_decoder_core_test.sv
